// ----- rtl/ptc_pkg.sv -----
// Shared types and constants for the programmable tick clock.
// Holds the item codes, the queued item layout and the timing constants.
// No dependencies.
package ptc_pkg;

  // Input mode codes.
  localparam logic [1:0] MODE_CMD  = 2'd0;
  localparam logic [1:0] MODE_TIME = 2'd1;
  localparam logic [1:0] MODE_POLL = 2'd2;

  // Command numbers carried in register A.
  localparam logic [15:0] CMD_SET_RATE  = 16'd0;
  localparam logic [15:0] CMD_READ_TICK = 16'd1;
  localparam logic [15:0] CMD_SET_MSG   = 16'd2;

  // Field widths.
  localparam int WordW   = 16;
  localparam int ElapsW  = 20;
  localparam int PeriodW = 26;
  localparam int AccW    = 27;

  // One minute in microseconds, the dividend of the period computation.
  localparam logic [PeriodW-1:0] CLOCK_MINUTE_US = 26'd60000000;
  // Saturation value of the time accumulator.
  localparam logic [AccW-1:0] ACC_MAX = '1;

  // Operation classes decided by the front end.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_SET_RATE,
    OP_STOP_CLOCK,
    OP_READ_TICK,
    OP_SET_MSG,
    OP_TIME,
    OP_POLL
  } op_t;

  // One classified item as it sits in the queue.
  typedef struct packed {
    op_t              op;
    logic [WordW-1:0] operand;
    logic [ElapsW-1:0] elapsed;
  } item_t;

endpackage

// ----- rtl/programmable_tick_clock_device.sv -----
// Programmable tick clock, top level.
// Usage:
//   Each input beat (in_valid/in_stall) carries a mode and its operands: a
//   command (set rate, read tick count, set interrupt message), an elapsed-time
//   advance, or an interrupt poll. Every beat gives exactly one result beat
//   (out_valid/out_stall) with c_valid/c_value and irq_valid/irq_message;
//   beats with nothing to report carry all-zero fields.
//   A beat is taken at a rising edge with valid high and stall low.
// Timing:
//   Beats pass through a short queue into the execution unit. Most beats are
//   registered in the queue and then in the output register, and one beat per
//   cycle is sustained while out_stall is low and no division runs. A set-rate
//   command with a nonzero divider runs the period division on a serial
//   divider, one quotient bit per cycle over 26 bits, so its result comes
//   once the division ends, and later beats wait in the queue meanwhile.
// Reset:
//   rst is synchronous and active high; it empties the queue, stops the clock
//   and clears the period, accumulator, tick count, message and pending mark.
// Stalls:
//   While out_stall holds, the result stays in the output register; the queue
//   keeps taking input beats until it is full, then raises in_stall.
// Depends on ptc_pkg, ptc_front, ptc_queue and ptc_back.
module programmable_tick_clock_device import ptc_pkg::*; #(
  parameter int QueueDepth = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        mode,
  input  logic [WordW-1:0]  reg_a,
  input  logic [WordW-1:0]  reg_b,
  input  logic [ElapsW-1:0] elapsed_us,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              c_valid,
  output logic [WordW-1:0]  c_value,
  output logic              irq_valid,
  output logic [WordW-1:0]  irq_message
);

  logic  push_valid;
  logic  push_ready;
  item_t push_item;
  logic  head_valid;
  item_t head_item;
  logic  pop_en;

  ptc_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .reg_a      (reg_a),
    .reg_b      (reg_b),
    .elapsed_us (elapsed_us),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  ptc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (head_valid),
    .pop_item   (head_item),
    .pop_en     (pop_en)
  );

  ptc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_item   (head_item),
    .pop_en      (pop_en),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .c_valid     (c_valid),
    .c_value     (c_value),
    .irq_valid   (irq_valid),
    .irq_message (irq_message)
  );

endmodule

// ----- rtl/ptc_front.sv -----
// Front end of the programmable tick clock: takes input beats and classifies them.
// Depends on ptc_pkg for the item codes and the queued item layout.
module ptc_front import ptc_pkg::*; (
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        mode,
  input  logic [WordW-1:0]  reg_a,
  input  logic [WordW-1:0]  reg_b,
  input  logic [ElapsW-1:0] elapsed_us,
  output logic              push_valid,
  output item_t             push_item,
  input  logic              push_ready
);

  // The queue decides whether a beat can be taken.
  assign in_stall   = !push_ready;
  assign push_valid = in_valid;

  // Classify the beat into one operation for the back end.
  always_comb begin
    push_item.op      = OP_NOP;
    push_item.operand = reg_b;
    push_item.elapsed = elapsed_us;
    unique case (mode)
      MODE_CMD: begin
        if (reg_a == CMD_SET_RATE) begin
          push_item.op = (reg_b == '0) ? OP_STOP_CLOCK : OP_SET_RATE;
        end else if (reg_a == CMD_READ_TICK) begin
          push_item.op = OP_READ_TICK;
        end else if (reg_a == CMD_SET_MSG) begin
          push_item.op = OP_SET_MSG;
        end
      end
      MODE_TIME: push_item.op = OP_TIME;
      MODE_POLL: push_item.op = OP_POLL;
      default:   push_item.op = OP_NOP;
    endcase
  end

endmodule

// ----- rtl/ptc_queue.sv -----
// Short queue of classified items between the front and back ends.
// Depends on ptc_pkg for the item layout.
module ptc_queue import ptc_pkg::*; #(
  parameter int Depth = 2
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  input  item_t push_item,
  output logic  push_ready,
  output logic  pop_valid,
  output item_t pop_item,
  input  logic  pop_en
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  item_t            entries [Depth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             push_fire;
  logic             pop_fire;

  assign push_ready = (count != CntW'(Depth));
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_en && pop_valid;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push_fire && !pop_fire) begin
        count <= count + 1'b1;
      end else if (pop_fire && !push_fire) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push_fire) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // The fill count never passes the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Depth))
    else $error("queue count exceeds depth");

endmodule

// ----- rtl/ptc_div.sv -----
// Serial restoring divider that turns a rate divider into a tick period.
// Computes one minute in microseconds over the divisor, one quotient bit per cycle.
// Depends on ptc_pkg for the dividend and widths.
module ptc_div import ptc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [WordW-1:0]   divisor,
  output logic               done,
  output logic [PeriodW-1:0] quotient
);

  localparam int StepW = $clog2(PeriodW);

  logic               busy;
  logic [StepW-1:0]   step;
  logic [WordW-1:0]   dvs;
  logic [WordW-1:0]   rem;
  logic [PeriodW-1:0] quo;
  logic [WordW:0]     trial;
  logic [WordW:0]     diff;
  logic               fits;

  // One restoring step: bring in the next dividend bit and try a subtract.
  assign trial    = {rem, quo[PeriodW-1]};
  assign diff     = trial - {1'b0, dvs};
  assign fits     = (trial >= {1'b0, dvs});
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= StepW'(PeriodW - 1);
        rem  <= '0;
        quo  <= CLOCK_MINUTE_US;
        dvs  <= divisor;
      end else if (busy) begin
        rem  <= fits ? diff[WordW-1:0] : trial[WordW-1:0];
        quo  <= {quo[PeriodW-2:0], fits};
        step <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/ptc_back.sv -----
// Back end of the programmable tick clock: executes queued items and holds the result.
// Owns the clock state, the serial period divider and the output register.
// Depends on ptc_pkg and ptc_div.
module ptc_back import ptc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  item_t             head_item,
  output logic              pop_en,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              c_valid,
  output logic [WordW-1:0]  c_value,
  output logic              irq_valid,
  output logic [WordW-1:0]  irq_message
);

  typedef enum logic {ST_RUN, ST_DIV} state_t;

  state_t              state;
  logic [WordW-1:0]    rate_divider;
  logic [PeriodW-1:0]  period_us;
  logic [AccW-1:0]     time_accumulator;
  logic [WordW-1:0]    tick_count;
  logic [WordW-1:0]    message_word;
  logic                irq_pending;

  logic                slot_free;
  logic                pop_fire;
  logic                div_start;
  logic                div_done;
  logic [PeriodW-1:0]  div_quo;
  logic [AccW:0]       sum_wide;
  logic [AccW-1:0]     sum_sat;
  logic                tick_hit;
  logic [AccW-1:0]     acc_next;

  // Issue control: a new item runs only when the result register can take it.
  assign slot_free = !out_valid || !out_stall;
  assign pop_fire  = (state == ST_RUN) && head_valid && slot_free;
  assign pop_en    = pop_fire;
  assign div_start = pop_fire && (head_item.op == OP_SET_RATE);

  ptc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (head_item.operand),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Accumulator update for a time beat: saturating add, then at most one tick.
  always_comb begin
    sum_wide = {1'b0, time_accumulator} + (AccW + 1)'(head_item.elapsed);
    sum_sat  = sum_wide[AccW] ? ACC_MAX : sum_wide[AccW-1:0];
    tick_hit = (sum_sat >= AccW'(period_us));
    acc_next = tick_hit ? (sum_sat - AccW'(period_us)) : sum_sat;
  end

  // State, clock registers and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_RUN;
      out_valid        <= 1'b0;
      rate_divider     <= '0;
      period_us        <= '0;
      time_accumulator <= '0;
      tick_count       <= '0;
      message_word     <= '0;
      irq_pending      <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_RUN: begin
          if (pop_fire) begin
            out_valid   <= 1'b1;
            c_valid     <= 1'b0;
            c_value     <= '0;
            irq_valid   <= 1'b0;
            irq_message <= '0;
            unique case (head_item.op)
              OP_SET_RATE: begin
                // The result waits for the period division to finish.
                out_valid    <= 1'b0;
                rate_divider <= head_item.operand;
                tick_count   <= '0;
                state        <= ST_DIV;
              end
              OP_STOP_CLOCK: begin
                rate_divider <= '0;
                tick_count   <= '0;
              end
              OP_READ_TICK: begin
                c_valid <= 1'b1;
                c_value <= tick_count;
              end
              OP_SET_MSG: begin
                message_word <= head_item.operand;
              end
              OP_TIME: begin
                if (rate_divider != '0) begin
                  time_accumulator <= acc_next;
                  if (tick_hit) begin
                    tick_count  <= tick_count + 1'b1;
                    irq_pending <= (message_word != '0);
                  end
                end
              end
              OP_POLL: begin
                if (irq_pending && (message_word != '0)) begin
                  irq_pending <= 1'b0;
                  irq_valid   <= 1'b1;
                  irq_message <= message_word;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_DIV: begin
          if (div_done) begin
            period_us <= div_quo;
            out_valid <= 1'b1;
            state     <= ST_RUN;
          end
        end
        default: state <= ST_RUN;
      endcase
    end
  end

  // No result is held while a division is in flight.
  a_div_no_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> !out_valid)
    else $error("result held during period division");

  // The divider finishes only while the back end waits for it.
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside the wait state");

  // Setting or stopping the rate clears the tick count.
  a_rate_clears_ticks: assert property (@(posedge clk) disable iff (rst)
    (pop_fire && ((head_item.op == OP_SET_RATE) || (head_item.op == OP_STOP_CLOCK)))
      |=> (tick_count == '0))
    else $error("tick count not cleared by rate command");

  // A read result and an interrupt result never come together.
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(c_valid && irq_valid))
    else $error("read and interrupt results in one beat");

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for programmable_tick_clock_device: drives command, time
// and poll beats with random idling and checks every result beat against a
// tick clock tracker. Depends on ptc_pkg and the RTL under rtl/.
module tb_top import ptc_pkg::*; ();

  localparam logic [1:0]  MODE_UNUSED      = 2'd3;
  localparam logic [15:0] CMD_FIRST_UNUSED = 16'd3;
  localparam logic [15:0] WORD_MAX         = 16'hFFFF;
  localparam logic [ElapsW-1:0] ELAPSED_MAX = '1;
  localparam int RANDOM_BEATS = 1950;
  localparam int SAT_RUN      = 150;
  localparam int TAIL_CYCLES  = 40;
  localparam int CYCLE_LIMIT  = 1000000;

  // One result beat as the block presents it.
  typedef struct packed {
    logic             c_valid;
    logic [WordW-1:0] c_value;
    logic             irq_valid;
    logic [WordW-1:0] irq_message;
  } clock_result_t;

  // Tracks the clock state beat by beat and holds the results still owed.
  class tick_clock_tracker;
    logic [WordW-1:0]   rate_div = '0;
    logic [PeriodW-1:0] period = '0;
    logic [AccW-1:0]    accum = '0;
    logic [WordW-1:0]   ticks = '0;
    logic [WordW-1:0]   message = '0;
    logic               irq_armed = 1'b0;
    clock_result_t      owed_results[$];
    int                 failures = 0;

    // Advance the clock state for one accepted input beat.
    function void note_beat(logic [1:0] m, logic [WordW-1:0] a, logic [WordW-1:0] b,
                            logic [ElapsW-1:0] el);
      clock_result_t      res;
      logic [AccW:0]      sum;
      logic [PeriodW-1:0] divisor;
      res = '0;
      divisor = PeriodW'(b);
      case (m)
        MODE_CMD: begin
          if (a == CMD_SET_RATE) begin
            rate_div = b;
            if (b != '0) period = CLOCK_MINUTE_US / divisor;
            ticks = '0;
          end else if (a == CMD_READ_TICK) begin
            res.c_valid = 1'b1;
            res.c_value = ticks;
          end else if (a == CMD_SET_MSG) begin
            message = b;
          end
        end
        MODE_TIME: begin
          // The clock only runs with a nonzero divider; at most one tick per beat.
          if (rate_div != '0) begin
            sum = {1'b0, accum} + (AccW + 1)'(el);
            if (sum > {1'b0, ACC_MAX}) sum = {1'b0, ACC_MAX};
            accum = sum[AccW-1:0];
            if (accum >= AccW'(period)) begin
              accum = accum - AccW'(period);
              ticks = ticks + 1'b1;
              irq_armed = (message != '0);
            end
          end
        end
        MODE_POLL: begin
          if (irq_armed && message != '0) begin
            irq_armed = 1'b0;
            res.irq_valid = 1'b1;
            res.irq_message = message;
          end
        end
        default: ;
      endcase
      owed_results.push_back(res);
    endfunction

    function void check_field(string name, logic [WordW-1:0] want, logic [WordW-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        failures++;
      end
    endfunction

    // Compare one accepted result beat with the oldest owed result.
    function void check_beat(logic cv, logic [WordW-1:0] cval, logic iv,
                             logic [WordW-1:0] imsg);
      clock_result_t want;
      if (owed_results.size() == 0) begin
        $display("%0t: result beat with nothing owed: expected none, actual %0h %0h %0h %0h",
                 $time, cv, cval, iv, imsg);
        failures++;
      end else begin
        want = owed_results.pop_front();
        check_field("c_valid", WordW'(want.c_valid), WordW'(cv));
        check_field("c_value", want.c_value, cval);
        check_field("irq_valid", WordW'(want.irq_valid), WordW'(iv));
        check_field("irq_message", want.irq_message, imsg);
      end
    endfunction

    function int owed();
      return owed_results.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        mode;
  logic [WordW-1:0]  reg_a;
  logic [WordW-1:0]  reg_b;
  logic [ElapsW-1:0] elapsed_us;
  logic              out_valid;
  logic              out_stall;
  logic              c_valid;
  logic [WordW-1:0]  c_value;
  logic              irq_valid;
  logic [WordW-1:0]  irq_message;

  tick_clock_tracker tracker;
  int unsigned       cycle_count = 0;
  int                beats_sent = 0;

  programmable_tick_clock_device uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .reg_a(reg_a), .reg_b(reg_b), .elapsed_us(elapsed_us),
    .out_valid(out_valid), .out_stall(out_stall),
    .c_valid(c_valid), .c_value(c_value),
    .irq_valid(irq_valid), .irq_message(irq_message)
  );

  always #5 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Observe beats on both channels.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) tracker.note_beat(mode, reg_a, reg_b, elapsed_us);
    if (!rst && out_valid && !out_stall) tracker.check_beat(c_valid, c_value, irq_valid,
                                                            irq_message);
  end

  // Receiver stalls: mostly short, a few long, with stretches of none.
  initial begin
    int run_len;
    int stall_len;
    forever begin
      if ($urandom_range(0, 9) == 0) begin
        out_stall <= 1'b0;
        repeat (200) @(posedge clk);
      end else begin
        run_len = $urandom_range(1, 8);
        case ($urandom_range(0, 19))
          0:       stall_len = $urandom_range(20, 40);
          1, 2, 3: stall_len = $urandom_range(4, 10);
          default: stall_len = $urandom_range(1, 3);
        endcase
        out_stall <= 1'b0;
        repeat (run_len) @(posedge clk);
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  // Sender gap: none most of the time, some short, a few long; none at all in
  // every third stretch of beats.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if ((beats_sent / 150) % 3 == 2) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Present one beat and hold it until the block takes it.
  task automatic send_beat(input logic [1:0] m, input logic [WordW-1:0] a,
                           input logic [WordW-1:0] b, input logic [ElapsW-1:0] el);
    int gap;
    gap = pick_gap();
    mode <= m;
    reg_a <= a;
    reg_b <= b;
    elapsed_us <= el;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off the sender until every owed result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.owed() != 0) @(posedge clk);
  endtask

  function automatic logic [WordW-1:0] rand_word();
    return WordW'($urandom);
  endfunction

  function automatic logic [ElapsW-1:0] rand_elapsed();
    case ($urandom_range(0, 9))
      0:       return ELAPSED_MAX;
      1, 2:    return ElapsW'($urandom_range(0, 2000));
      default: return ElapsW'($urandom);
    endcase
  endfunction

  // Divider choice: slow rates that tick now and then, fast rates, stop, extremes.
  function automatic logic [WordW-1:0] rand_divider();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return WORD_MAX;
      2:       return 16'd1;
      3, 4, 5: return rand_word();
      default: return WordW'($urandom_range(1, 200));
    endcase
  endfunction

  // One random beat; ignored kinds do not count toward the total.
  task automatic random_beat(output bit counted);
    int r;
    r = $urandom_range(0, 99);
    counted = 1'b1;
    if (r < 4) begin
      send_beat(MODE_UNUSED, rand_word(), rand_word(), ElapsW'($urandom));
      counted = 1'b0;
    end else if (r < 7) begin
      send_beat(MODE_CMD, WordW'($urandom_range(CMD_FIRST_UNUSED, WORD_MAX)), rand_word(),
                ElapsW'($urandom));
      counted = 1'b0;
    end else if (r < 10) begin
      send_beat(MODE_CMD, CMD_SET_RATE, rand_divider(), ElapsW'($urandom));
    end else if (r < 18) begin
      send_beat(MODE_CMD, CMD_READ_TICK, rand_word(), ElapsW'($urandom));
    end else if (r < 23) begin
      send_beat(MODE_CMD, CMD_SET_MSG, ($urandom_range(0, 4) == 0) ? '0 : rand_word(),
                ElapsW'($urandom));
    end else if (r < 70) begin
      send_beat(MODE_TIME, rand_word(), rand_word(), rand_elapsed());
    end else begin
      send_beat(MODE_POLL, rand_word(), rand_word(), ElapsW'($urandom));
    end
  endtask

  // Fast clock fed with full elapsed times until the accumulator pins at its top.
  task automatic saturation_run(output int n);
    send_beat(MODE_CMD, CMD_SET_MSG, rand_word() | 16'd1, '0);
    send_beat(MODE_CMD, CMD_SET_RATE, WORD_MAX - WordW'($urandom_range(0, 255)), '0);
    repeat (SAT_RUN) send_beat(MODE_TIME, rand_word(), rand_word(), ELAPSED_MAX);
    send_beat(MODE_POLL, '0, '0, '0);
    send_beat(MODE_CMD, CMD_READ_TICK, '0, '0);
    n = SAT_RUN + 4;
  endtask

  initial begin
    int  random_done;
    int  run_n;
    bit  counted;
    bit  mid_drained;
    rst <= 1'b1;
    in_valid <= 1'b0;
    mode <= MODE_CMD;
    reg_a <= '0;
    reg_b <= '0;
    elapsed_us <= '0;
    tracker = new;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: quiet state, unknown codes, tick edges, message clearing,
    // stopping the clock and the slowest rate.
    send_beat(MODE_POLL, WORD_MAX, WORD_MAX, ELAPSED_MAX);
    send_beat(MODE_CMD, CMD_READ_TICK, WORD_MAX, ELAPSED_MAX);
    send_beat(MODE_TIME, '0, '0, ELAPSED_MAX);
    send_beat(MODE_UNUSED, WORD_MAX, WORD_MAX, ELAPSED_MAX);
    send_beat(MODE_CMD, CMD_FIRST_UNUSED, WORD_MAX, ELAPSED_MAX);
    send_beat(MODE_CMD, WORD_MAX, WORD_MAX, '0);
    send_beat(MODE_CMD, CMD_SET_MSG, WORD_MAX, '0);
    send_beat(MODE_CMD, CMD_SET_RATE, WORD_MAX, '0);
    send_beat(MODE_TIME, '0, '0, '0);
    send_beat(MODE_TIME, '0, '0, 20'd914);
    send_beat(MODE_TIME, '0, '0, 20'd1);
    send_beat(MODE_POLL, '0, '0, '0);
    send_beat(MODE_POLL, '0, '0, '0);
    send_beat(MODE_CMD, CMD_READ_TICK, '0, '0);
    send_beat(MODE_TIME, '0, '0, ELAPSED_MAX);
    send_beat(MODE_CMD, CMD_SET_MSG, '0, '0);
    send_beat(MODE_TIME, '0, '0, '0);
    send_beat(MODE_CMD, CMD_SET_MSG, 16'h8001, '0);
    send_beat(MODE_POLL, '0, '0, '0);
    send_beat(MODE_CMD, CMD_SET_RATE, '0, '0);
    send_beat(MODE_TIME, '0, '0, ELAPSED_MAX);
    send_beat(MODE_CMD, CMD_READ_TICK, '0, '0);
    send_beat(MODE_CMD, CMD_SET_RATE, 16'd1, '0);
    send_beat(MODE_TIME, '0, '0, ELAPSED_MAX);
    send_beat(MODE_CMD, CMD_READ_TICK, '0, '0);
    drain_results();

    // Random beats, with a saturating run now and then and one mid-run drain.
    random_done = 0;
    mid_drained = 1'b0;
    while (random_done < RANDOM_BEATS) begin
      if (random_done % 700 == 350) begin
        saturation_run(run_n);
        random_done += run_n;
      end else begin
        random_beat(counted);
        if (counted) random_done++;
      end
      if (!mid_drained && random_done >= RANDOM_BEATS / 2) begin
        drain_results();
        mid_drained = 1'b1;
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.failures == 0 && tracker.owed() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/ptc_pkg.sv
rtl/ptc_front.sv
rtl/ptc_queue.sv
rtl/ptc_div.sv
rtl/ptc_back.sv
rtl/programmable_tick_clock_device.sv
bench/tb_top.sv
